// ===== rtl/cdq_pkg.sv =====
// Package for the circular deque core: request and state types, status codes
// and fixed field widths. Depends on nothing.
package cdq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] POP_NONE  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_POP_WAIT
  } state_e;

endpackage

// ===== rtl/cdq_store.sv =====
// Element store of the circular deque: one write port, one registered read port.
// Depends on cdq_pkg for the data width.
module cdq_store import cdq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/circular_deque_core.sv =====
// Top level of the circular deque: pointer control, capacity register and
// result register around the element store. Depends on cdq_pkg and cdq_store.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | req_type_i, push_value_i
//  out     | output    | out_valid_o / out_stall_i | pop_value_o, status_o,
//          |           |                         | now_empty_o, now_full_o
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (capacity)
//
// A push or a refused pop writes the result register directly; a pop that succeeds
// goes through the registered read of the store and S_POP_WAIT first. The result
// register lets a new transaction be taken while the previous result is being handed over.
// Reset clears pointers, empty flag, capacity (16) and control; the store is
// not cleared. A stalled result holds the input side once it blocks the register.
module circular_deque_core import cdq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] pop_value_o,
  output logic [1:0]               status_o,
  output logic                     now_empty_o,
  output logic                     now_full_o,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_wdata_i
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_e state_q, state_d;

  logic [IDX_W-1:0]  front_q, front_d, rear_q, rear_d;
  logic              empty_q, empty_d;
  logic [CAP_W-1:0]  capacity_q;
  logic [IDX_W-1:0]  cap_last;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;
  logic              out_empty_q, out_empty_d;
  logic              out_full_q, out_full_d;

  logic              accept;
  logic              full_now;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  function automatic logic [IDX_W-1:0] idx_inc(logic [IDX_W-1:0] x, logic [IDX_W-1:0] last);
    return (x == last) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(logic [IDX_W-1:0] x, logic [IDX_W-1:0] last);
    return (x == '0) ? last : x - 1'b1;
  endfunction

  // last usable index: capacity clamped to 1..DEPTH, minus one
  always_comb begin
    priority if (capacity_q == '0) begin
      cap_last = '0;
    end else if (32'(capacity_q) > DEPTH) begin
      cap_last = IDX_W'(DEPTH - 1);
    end else begin
      cap_last = IDX_W'(capacity_q - 1'b1);
    end
  end

  assign full_now   = !empty_q && (idx_inc(rear_q, cap_last) == front_q);
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !empty_q &&
            (req_e'(req_type_i) == REQ_POP_FRONT || req_e'(req_type_i) == REQ_POP_REAR)) begin
          state_d = S_POP_WAIT;
        end
      end
      S_POP_WAIT: state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    front_d      = front_q;
    rear_d       = rear_q;
    empty_d      = empty_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_re       = 1'b0;
    mem_raddr    = front_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;

    if (state_q == S_POP_WAIT) begin
      out_valid_d = 1'b1;
      out_value_d = mem_rdata;
    end else if (accept) begin
      out_status_d = ST_DONE;
      out_value_d  = POP_NONE;
      unique case (req_e'(req_type_i))
        REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
          out_valid_d = 1'b1;
          if (full_now) begin
            out_status_d = ST_FULL;
          end else if (empty_q) begin
            front_d   = '0;
            rear_d    = '0;
            empty_d   = 1'b0;
            mem_we    = 1'b1;
            mem_waddr = '0;
          end else if (req_e'(req_type_i) == REQ_PUSH_FRONT) begin
            front_d   = idx_dec(front_q, cap_last);
            mem_we    = 1'b1;
            mem_waddr = front_d;
          end else begin
            rear_d    = idx_inc(rear_q, cap_last);
            mem_we    = 1'b1;
            mem_waddr = rear_d;
          end
        end
        REQ_POP_FRONT, REQ_POP_REAR: begin
          if (empty_q) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_EMPTY;
          end else begin
            // result goes valid when the read data returns
            out_valid_d = 1'b0;
            mem_re      = 1'b1;
            if (front_q == rear_q) begin
              front_d = '0;
              rear_d  = '0;
              empty_d = 1'b1;
            end else if (req_e'(req_type_i) == REQ_POP_FRONT) begin
              front_d = idx_inc(front_q, cap_last);
            end else begin
              rear_d  = idx_dec(rear_q, cap_last);
            end
            mem_raddr = (req_e'(req_type_i) == REQ_POP_FRONT) ? front_q : rear_q;
          end
        end
        default: ;
      endcase
      out_empty_d = empty_d;
      out_full_d  = !empty_d && (idx_inc(rear_d, cap_last) == front_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      empty_q     <= 1'b1;
      capacity_q  <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && empty_q) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_empty_q  <= out_empty_d;
    out_full_q   <= out_full_d;
  end

  cdq_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (push_value_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign pop_value_o = out_value_q;
  assign status_o    = out_status_q;
  assign now_empty_o = out_empty_q;
  assign now_full_o  = out_full_q;

endmodule

// ===== tb/circular_deque_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for circular_deque_core: a clocked driver and monitor
// around the core, with a built-in deque predictor. Depends on cdq_pkg and the RTL.
module circular_deque_core_tb import cdq_pkg::*; ();

  localparam int RING_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int IDLE_PCT    = 23;
  localparam int RAND_ITEMS  = 850;

  typedef struct {
    req_e              op;
    logic [DATA_W-1:0] val;
  } deque_req_t;

  typedef struct {
    logic [DATA_W-1:0] pop_value;
    status_e           status;
    logic              now_empty;
    logic              now_full;
  } deque_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               req_type_i;
  logic signed [DATA_W-1:0] push_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] pop_value_o;
  logic [1:0]               status_o;
  logic                     now_empty_o;
  logic                     now_full_o;
  logic                     cfg_we_i;
  logic [CAP_W-1:0]         cfg_wdata_i;

  // predictor state
  logic [DATA_W-1:0] ring [RING_DEPTH];
  int                front_ptr;
  int                rear_ptr;
  int                fill_cnt;
  bit                pred_empty;
  logic [CAP_W-1:0]  cap_reg;

  deque_req_t    pending_q [$];
  deque_result_t want_q [$];
  deque_req_t    cur_item;
  deque_result_t exp_res;
  deque_result_t new_res;

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned queued_cnt;
  int unsigned taken_cnt;
  int          hold_left;
  bit          hold_req;
  bit          steady;
  bit          in_taken;

  circular_deque_core #(
    .DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .push_value_i(push_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pop_value_o (pop_value_o),
    .status_o    (status_o),
    .now_empty_o (now_empty_o),
    .now_full_o  (now_full_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int usable_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > RING_DEPTH) return RING_DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic bit ring_full();
    int c;
    int nxt;
    c = usable_cap();
    if (pred_empty) return 1'b0;
    nxt = (rear_ptr + 1 >= c) ? 0 : rear_ptr + 1;
    return nxt == front_ptr;
  endfunction

  function automatic deque_result_t serve_request(req_e op, logic [DATA_W-1:0] val);
    deque_result_t r;
    int c;
    c = usable_cap();
    r.pop_value = POP_NONE;
    r.status    = ST_DONE;
    front_ptr   = front_ptr % c;
    rear_ptr    = rear_ptr % c;
    if (op == REQ_PUSH_FRONT || op == REQ_PUSH_REAR) begin
      if (ring_full()) begin
        r.status = ST_FULL;
      end else if (pred_empty) begin
        front_ptr  = 0;
        rear_ptr   = 0;
        pred_empty = 1'b0;
        ring[0]    = val;
        fill_cnt   = 1;
      end else if (op == REQ_PUSH_FRONT) begin
        front_ptr = (front_ptr == 0) ? c - 1 : front_ptr - 1;
        ring[front_ptr] = val;
        fill_cnt++;
      end else begin
        rear_ptr = (rear_ptr + 1 >= c) ? 0 : rear_ptr + 1;
        ring[rear_ptr] = val;
        fill_cnt++;
      end
    end else if (pred_empty) begin
      r.status = ST_EMPTY;
    end else begin
      r.pop_value = (op == REQ_POP_FRONT) ? ring[front_ptr] : ring[rear_ptr];
      fill_cnt--;
      if (front_ptr == rear_ptr) begin
        pred_empty = 1'b1;
        front_ptr  = 0;
        rear_ptr   = 0;
      end else if (op == REQ_POP_FRONT) begin
        front_ptr = (front_ptr + 1 >= c) ? 0 : front_ptr + 1;
      end else begin
        rear_ptr = (rear_ptr == 0) ? c - 1 : rear_ptr - 1;
      end
    end
    r.now_empty = pred_empty;
    r.now_full  = ring_full();
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("%0t: %s", $time, msg);
  endtask

  // monitor: checks results, predicts on every accepted request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (want_q.size() == 0) begin
          flag_mismatch("result transaction with nothing expected");
        end else begin
          exp_res = want_q.pop_front();
          if (pop_value_o !== exp_res.pop_value)
            flag_mismatch($sformatf("pop_value %h, expected %h", pop_value_o,
                                    exp_res.pop_value));
          if (status_o !== exp_res.status)
            flag_mismatch($sformatf("status %0d, expected %0d", status_o, exp_res.status));
          if (now_empty_o !== exp_res.now_empty)
            flag_mismatch($sformatf("now_empty %b, expected %b", now_empty_o,
                                    exp_res.now_empty));
          if (now_full_o !== exp_res.now_full)
            flag_mismatch($sformatf("now_full %b, expected %b", now_full_o,
                                    exp_res.now_full));
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        new_res = serve_request(req_e'(req_type_i), push_value_i);
        want_q.push_back(new_res);
        taken_cnt++;
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        cur_item = pending_q.pop_front();
        req_type_i   <= cur_item.op;
        push_value_i <= cur_item.val;
        in_valid_i   <= 1'b1;
      end else begin
        req_type_i   <= 2'($urandom_range(3));
        push_value_i <= $urandom;
        in_valid_i   <= 1'b0;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 90;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(req_e op, logic [DATA_W-1:0] v);
    deque_req_t it;
    it.op  = op;
    it.val = v;
    pending_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic wait_idle();
    while (taken_cnt != queued_cnt || want_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    if (pred_empty) cap_reg = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CAP_W'($urandom);
  endtask

  // push_pct sets the bias: high fills the deque, low drains it
  task automatic queue_burst(int n, int push_pct);
    req_e op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < push_pct)
        op = $urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
      else
        op = $urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT;
      queue_item(op, op inside {REQ_PUSH_FRONT, REQ_PUSH_REAR} ? pick_value() : $urandom);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap_plan [10];
    int phase;
    int rand_cnt;
    int phase_cnt;
    int n;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = '0;
    push_value_i = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    front_ptr    = 0;
    rear_ptr     = 0;
    fill_cnt     = 0;
    pred_empty   = 1'b1;
    cap_reg      = CAP_RESET;
    cycle_cnt    = 0;
    err_cnt      = 0;
    queued_cnt   = 0;
    taken_cnt    = 0;
    hold_left    = 0;
    hold_req     = 1'b0;
    steady       = 1'b0;
    in_taken     = 1'b0;
    cap_plan     = '{5'd16, 5'd31, 5'd2, 5'd0, 5'd5, 5'd17, 5'd1, 5'd3, 5'd16, 5'd9};

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset capacity: empty pops, last element popped, extremes of the value
    queue_item(REQ_POP_FRONT, 32'h1234_5678);
    queue_item(REQ_POP_REAR, 32'hFFFF_FFFF);
    queue_item(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    queue_item(REQ_POP_REAR, 32'h0);
    queue_item(REQ_PUSH_REAR, 32'h8000_0000);
    queue_item(REQ_PUSH_FRONT, 32'h0000_0000);
    queue_item(REQ_PUSH_REAR, 32'hFFFF_FFFF);
    queue_item(REQ_POP_FRONT, 32'h0);
    queue_item(REQ_POP_REAR, 32'h0);
    queue_item(REQ_POP_FRONT, 32'h0);
    queue_item(REQ_POP_FRONT, 32'h0);
    wait_idle();

    // capacity 1: full refusal on both ends
    write_capacity(5'd1);
    queue_item(REQ_PUSH_FRONT, 32'hA5A5_5A5A);
    queue_item(REQ_PUSH_REAR, 32'h0F0F_F0F0);
    queue_item(REQ_PUSH_FRONT, 32'h1);
    queue_item(REQ_POP_REAR, 32'h0);
    queue_item(REQ_PUSH_REAR, 32'h5555_AAAA);
    queue_item(REQ_POP_FRONT, 32'h0);
    wait_idle();

    // capacity 0 behaves as 1; left holding one element
    write_capacity(5'd0);
    queue_item(REQ_PUSH_REAR, 32'h3C3C_C3C3);
    queue_item(REQ_PUSH_FRONT, 32'h2);
    queue_item(REQ_POP_FRONT, 32'h0);
    queue_item(REQ_PUSH_FRONT, 32'hDEAD_0001);
    wait_idle();

    // write while not empty is ignored
    write_capacity(5'd31);
    queue_item(REQ_PUSH_REAR, 32'h3);
    queue_item(REQ_POP_REAR, 32'h0);
    queue_item(REQ_POP_REAR, 32'h0);
    wait_idle();

    rand_cnt = 0;
    phase    = 0;
    while (rand_cnt < RAND_ITEMS) begin
      // mostly drain first so the new capacity takes effect
      if ($urandom_range(9) != 0) begin
        while (fill_cnt > 0) begin
          n = fill_cnt;
          for (int i = 0; i < n; i++)
            queue_item($urandom_range(1) ? REQ_POP_FRONT : REQ_POP_REAR, $urandom);
          wait_idle();
        end
      end
      write_capacity(phase % 4 == 3 ? CAP_W'($urandom) : cap_plan[phase % 10]);
      steady = (phase == 3);
      phase_cnt = 0;
      while (phase_cnt < 95) begin
        n = 2 * usable_cap() + $urandom_range(1, 6);
        case ($urandom_range(4))
          0:       queue_burst(n, 50);
          1, 2:    queue_burst(n, 85);
          default: queue_burst(n, 20);
        endcase
        phase_cnt += n;
      end
      if (phase == 2 || phase == 7) hold_req = 1'b1;
      rand_cnt += phase_cnt;
      wait_idle();
      steady = 1'b0;
      phase++;
    end

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
